FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers shared by the RTL; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define SIDA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("sida assertion failed");

// Check that a trigger is followed by a consequence in the next cycle.
`define SIDA_ASSERT_NEXT(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("sida assertion failed");

`else

`define SIDA_ASSERT(label, clk, rst, prop)
`define SIDA_ASSERT_NEXT(label, clk, rst, trig, cons)

`endif

`endif

FILE: hdl/sida_pkg.sv
// ----------------------------------------------------------------------------
// sida_pkg
// Shared types, constants and the BCD adjust function of the integer to
// decimal text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sida_pkg;

  localparam int VALUE_W   = 64;
  localparam int CHAR_W    = 6;
  // 2^63 < 10^19, so 19 digits hold any magnitude
  localparam int NDIG      = 19;
  localparam int BCD_W     = NDIG * 4;
  localparam int DIG_CNT_W = 5;
  localparam int BIT_CNT_W = 6;

  localparam logic [CHAR_W-1:0]    CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0]    CHAR_NINE  = 6'd57;
  localparam logic [CHAR_W-1:0]    CHAR_MINUS = 6'd45;
  localparam logic [BIT_CNT_W-1:0] LAST_BIT   = 6'(VALUE_W - 1);
  localparam logic [DIG_CNT_W-1:0] ALL_DIGITS = 5'(NDIG);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_STRIP,
    ST_SIGN,
    ST_DIGITS
  } sida_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic shift;
    logic strip;
    logic emit;
    logic sel_sign;
  } sida_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bit_last;
    logic top_zero;
    logic one_left;
    logic neg;
  } sida_stat_t;

  // Add 3 to every BCD digit of 5 or more, ahead of the next left shift.
  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] res;
    res = bcd;
    for (int d = 0; d < NDIG; d++) begin
      if (bcd[d*4 +: 4] >= 4'd5) begin
        res[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/signed_int_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a signed 64-bit integer to its decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, value) takes one two's complement
//   integer per beat. Output channel (out_valid/out_ready) returns the text
//   one character per beat, most significant first: ascii_char holds the
//   minus sign (45) or a digit (48..57), last_char marks the final beat.
//   Zero gives a single '0'; no leading zeros are produced.
//   Sequence: load, shift-and-adjust steps of the double-dabble
//   register, up to 18 leading zero digits dropped, then one character
//   per beat (1..20 characters) while the receiver is ready.
//   The BCD shift loop takes one magnitude bit per cycle.
//   in_ready is high only while idle; one item is in flight at a time.
//   A stalled receiver holds the current character and the block waits.
//   Reset returns the sequencer to idle and drops any item in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module signed_int_to_decimal_ascii_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [sida_pkg::VALUE_W-1:0]  value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sida_pkg::CHAR_W-1:0]        ascii_char,
  output logic                               last_char
);

  sida_pkg::sida_cmd_t  cmd;
  sida_pkg::sida_stat_t stat;
  logic                 char_legal;

  sida_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sida_datapath u_datapath (
    .clk        (clk),
    .value      (value),
    .cmd        (cmd),
    .stat       (stat),
    .ascii_char (ascii_char),
    .last_char  (last_char)
  );

  // a minus sign or a decimal digit
  assign char_legal = (ascii_char == sida_pkg::CHAR_MINUS) ||
                      ((ascii_char >= sida_pkg::CHAR_ZERO) &&
                       (ascii_char <= sida_pkg::CHAR_NINE));

  // one item at a time: never take input while emitting
  `SIDA_ASSERT(a_no_overlap, clk, rst, !(in_ready && out_valid))
  // the final character hands control back to idle
  `SIDA_ASSERT_NEXT(a_last_to_idle, clk, rst, out_valid && out_ready && last_char, in_ready)
  // emitted characters are a minus sign or a decimal digit
  `SIDA_ASSERT(a_char_range, clk, rst, !out_valid || char_legal)
  // the sign never ends a run
  `SIDA_ASSERT(a_sign_not_last, clk, rst, !(out_valid && (ascii_char == sida_pkg::CHAR_MINUS) && last_char))

endmodule

`default_nettype wire

FILE: hdl/sida_ctrl.sv
// ----------------------------------------------------------------------------
// sida_ctrl
// Sequencer: load, 64 shift-and-adjust steps, leading zero strip, then
// the sign and digit beats.
// ----------------------------------------------------------------------------
`default_nettype none

module sida_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire sida_pkg::sida_stat_t stat,
  output sida_pkg::sida_cmd_t     cmd
);

  sida_pkg::sida_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sida_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      sida_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sida_pkg::ST_CONVERT;
        end
      end
      sida_pkg::ST_CONVERT: begin
        cmd.shift = 1'b1;
        if (stat.bit_last) begin
          state_next = sida_pkg::ST_STRIP;
        end
      end
      sida_pkg::ST_STRIP: begin
        // drop leading zeros, keeping at least one digit
        if (stat.top_zero && !stat.one_left) begin
          cmd.strip = 1'b1;
        end else if (stat.neg) begin
          state_next = sida_pkg::ST_SIGN;
        end else begin
          state_next = sida_pkg::ST_DIGITS;
        end
      end
      sida_pkg::ST_SIGN: begin
        out_valid    = 1'b1;
        cmd.sel_sign = 1'b1;
        if (out_ready) begin
          state_next = sida_pkg::ST_DIGITS;
        end
      end
      sida_pkg::ST_DIGITS: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit = 1'b1;
          if (stat.one_left) begin
            state_next = sida_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = sida_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/sida_datapath.sv
// ----------------------------------------------------------------------------
// sida_datapath
// Magnitude shifter, double-dabble BCD register, bit and digit counters,
// and the output character formatter.
// ----------------------------------------------------------------------------
`default_nettype none

module sida_datapath (
  input  wire logic                          clk,
  input  wire logic [sida_pkg::VALUE_W-1:0]  value,
  input  wire sida_pkg::sida_cmd_t           cmd,
  output sida_pkg::sida_stat_t               stat,
  output logic [sida_pkg::CHAR_W-1:0]        ascii_char,
  output logic                               last_char
);

  logic [sida_pkg::VALUE_W-1:0]   mag;
  logic [sida_pkg::BCD_W-1:0]     bcd;
  logic [sida_pkg::BIT_CNT_W-1:0] bit_cnt;
  logic [sida_pkg::DIG_CNT_W-1:0] ndig;
  logic                           neg;
  logic [sida_pkg::BCD_W-1:0]     bcd_adj;
  logic [3:0]                     top_digit;

  assign bcd_adj   = sida_pkg::dabble(bcd);
  assign top_digit = bcd[sida_pkg::BCD_W-1 -: 4];

  // load, shift-and-adjust, then shift digits out of the top
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg     <= value[sida_pkg::VALUE_W-1];
      mag     <= value[sida_pkg::VALUE_W-1] ? (~value + 64'd1) : value;
      bcd     <= '0;
      bit_cnt <= sida_pkg::LAST_BIT;
      ndig    <= sida_pkg::ALL_DIGITS;
    end else if (cmd.shift) begin
      mag     <= {mag[sida_pkg::VALUE_W-2:0], 1'b0};
      bcd     <= {bcd_adj[sida_pkg::BCD_W-2:0], mag[sida_pkg::VALUE_W-1]};
      bit_cnt <= bit_cnt - 6'd1;
    end else if (cmd.strip || cmd.emit) begin
      bcd     <= {bcd[sida_pkg::BCD_W-5:0], 4'd0};
      ndig    <= ndig - 5'd1;
    end
  end

  // status back to the controller
  always_comb begin
    stat.bit_last = (bit_cnt == '0);
    stat.top_zero = (top_digit == 4'd0);
    stat.one_left = (ndig == 5'd1);
    stat.neg      = neg;
  end

  // format the current beat
  assign ascii_char = cmd.sel_sign ? sida_pkg::CHAR_MINUS
                                   : sida_pkg::CHAR_ZERO + {2'b00, top_digit};
  assign last_char  = !cmd.sel_sign && (ndig == 5'd1);

endmodule

`default_nettype wire

FILE: test/sida_text_checker.sv
// ----------------------------------------------------------------------------
// sida_text_checker
// Watches both channels of the integer to decimal text converter. Every
// accepted input beat is expanded into the characters its decimal text
// should produce. Every accepted output beat is compared against the
// oldest character still waiting.
// ----------------------------------------------------------------------------
module sida_text_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [sida_pkg::VALUE_W-1:0]  value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [sida_pkg::CHAR_W-1:0]   ascii_char,
  input  logic                          last_char,
  output int                            failures,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [sida_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } text_char_t;

  text_char_t expected_chars[$];
  text_char_t oldest;
  int         fail_count = 0;

  initial begin
    failures = 0;
    pending  = 0;
  end

  // Expand one signed integer into its characters, sign first, and queue them
  function automatic void queue_decimal_text(input logic [sida_pkg::VALUE_W-1:0] v);
    logic [sida_pkg::VALUE_W-1:0] mag;
    logic [3:0]                   digit_buf[20];
    int                           n;
    text_char_t                   c;
    // two's complement magnitude; the most negative value stays exact unsigned
    mag = v[sida_pkg::VALUE_W-1] ? (~v + 64'd1) : v;
    n = 0;
    do begin
      digit_buf[n] = 4'(mag % 64'd10);
      n++;
      mag = mag / 64'd10;
    end while (mag != 64'd0);
    if (v[sida_pkg::VALUE_W-1]) begin
      c.ch   = sida_pkg::CHAR_MINUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
    end
    for (int i = n - 1; i >= 0; i--) begin
      c.ch   = sida_pkg::CHAR_W'(sida_pkg::CHAR_ZERO + digit_buf[i]);
      c.last = (i == 0);
      expected_chars.push_back(c);
    end
  endfunction

  // Predict on input beats, compare on output beats
  always @(posedge clk) begin
    if (rst) begin
      expected_chars.delete();
    end else begin
      if (in_valid && in_ready) begin
        queue_decimal_text(value);
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected output beat: ascii_char %0d last_char %0b",
                   $time, ascii_char, last_char);
        end else begin
          oldest = expected_chars.pop_front();
          if (ascii_char !== oldest.ch) begin
            fail_count++;
            $display("%0t: ascii_char mismatch: expected %0d actual %0d",
                     $time, oldest.ch, ascii_char);
          end
          if (last_char !== oldest.last) begin
            fail_count++;
            $display("%0t: last_char mismatch: expected %0b actual %0b",
                     $time, oldest.last, last_char);
          end
        end
      end
    end
    failures <= fail_count;
    pending  <= expected_chars.size();
  end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the integer to decimal text converter with corner values and
// random integers of every length and sign, under random gaps on the
// sender and random stalls on the receiver, including one long receiver
// hold-off. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_VALUES = 240;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int DRAIN_CYCLES  = 100;
  localparam int HOLD_CYCLES   = 400;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic [sida_pkg::VALUE_W-1:0]  value     = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [sida_pkg::CHAR_W-1:0]   ascii_char;
  logic                          last_char;
  int                            failures;
  int                            pending;
  int                            cycles    = 0;

  signed_int_to_decimal_ascii_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ascii_char (ascii_char),
    .last_char  (last_char)
  );

  sida_text_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ascii_char (ascii_char),
    .last_char  (last_char),
    .failures   (failures),
    .pending    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Bound the run
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_value(input logic [sida_pkg::VALUE_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Integer of random digit count and random sign
  function automatic logic [sida_pkg::VALUE_W-1:0] random_value();
    logic [sida_pkg::VALUE_W-1:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      v = v >> $urandom_range(0, 63);
      if ($urandom_range(0, 1) == 1) v = -v;
    end
    return v;
  endfunction

  // Receiver: bursts of ready, random stalls, one long hold-off
  initial begin
    int burst;
    int gap;
    int round;
    do @(posedge clk); while (rst);
    round = 0;
    forever begin
      if (round == 40) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (burst) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      round++;
    end
  end

  // Sender: corner values, then random integers, then drain and verdict
  initial begin
    logic [sida_pkg::VALUE_W-1:0] corner_values[21];
    corner_values = '{
      64'd0, 64'd1, -64'd1, 64'd9, 64'd10, -64'd9, -64'd10, 64'd99, 64'd100,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
      64'd999999999999999999, 64'd1000000000000000000, -64'd1000000000000000000,
      64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'd12345678901234567,
      64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000, 64'h8AC7_2304_89E8_0000
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (corner_values[i]) send_value(corner_values[i]);
    repeat (RANDOM_VALUES) send_value(random_value());
    in_valid <= 1'b0;
    // let the checker see the last beat before polling
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: signed_int_to_decimal_ascii_core.f
+incdir+hdl
hdl/sida_pkg.sv
hdl/sida_ctrl.sv
hdl/sida_datapath.sv
hdl/signed_int_to_decimal_ascii_core.sv
test/sida_text_checker.sv
test/tb_top.sv
